[design/tiff_directory_parser_assert.svh]
// Assertion macros used by the parser design file.
`ifndef TIFF_DIRECTORY_PARSER_ASSERT_SVH
`define TIFF_DIRECTORY_PARSER_ASSERT_SVH

`ifndef ASSERT_OFF

`define TDP_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tiff_directory_parser assertion failed");

`define TDP_ASSERT_IN_RESET(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) !rst_n |=> cond) \
        else $error("tiff_directory_parser reset assertion failed");

`else

`define TDP_ASSERT(label, clk, rst_n, prop)

`define TDP_ASSERT_IN_RESET(label, clk, rst_n, cond)

`endif

`endif

[design/tdp_pkg.sv]
package tdp_pkg;

    localparam logic [7:0]  ORDER_BIG_BYTE    = 8'h4D;
    localparam logic [7:0]  ORDER_LITTLE_BYTE = 8'h49;
    localparam logic [15:0] TIFF_MAGIC        = 16'd42;
    localparam logic [31:0] HEADER_BYTES      = 32'd8;
    localparam logic [15:0] DETAIL_TAG_RESET  = 16'd258;
    localparam logic [15:0] TYPE_FIRST        = 16'd1;
    localparam logic [15:0] TYPE_LAST         = 16'd12;

    localparam logic [3:0] IDX_TAG_LAST   = 4'd1;
    localparam logic [3:0] IDX_TYPE_LAST  = 4'd3;
    localparam logic [3:0] IDX_COUNT_LAST = 4'd7;
    localparam logic [3:0] IDX_ENTRY_LAST = 4'd11;
    localparam logic [3:0] IDX_OFFSET_LAST = 4'd3;

    typedef enum logic [8:0] {
        PH_ORDER  = 9'b000000001,
        PH_MAGIC  = 9'b000000010,
        PH_OFFSET = 9'b000000100,
        PH_SKIP   = 9'b000001000,
        PH_COUNT  = 9'b000010000,
        PH_ENTRY  = 9'b000100000,
        PH_AFTER  = 9'b001000000,
        PH_DONE   = 9'b010000000,
        PH_ERROR  = 9'b100000000
    } phase_t;

    typedef enum logic [2:0] {
        ST_ENTRY      = 3'd0,
        ST_BAD_ORDER  = 3'd1,
        ST_BAD_MAGIC  = 3'd2,
        ST_BAD_TYPE   = 3'd3,
        ST_BACKWARD   = 3'd4,
        ST_DIR_DONE   = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       file_start;
    } byte_item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] entry_tag;
        logic [15:0] entry_type;
        logic [31:0] value_count;
        logic [31:0] entry_value;
        logic [15:0] entry_number;
        logic        is_detail;
        logic        big_endian;
    } entry_item_t;

    typedef logic [15:0] detail_tag_t;

endpackage

[design/tdp_stream_if.sv]
interface tdp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[design/tiff_directory_parser.sv]
// A result transaction is registered and appears in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle while the output is not stalled, set by the single state update register stage.
// The output register frees as its transaction is taken, so input flows while it drains.
// Reset is asynchronous and active low; it restarts parsing and sets the detail tag to 258.
// No clearing pass is needed after reset.
`include "tiff_directory_parser_assert.svh"

module tiff_directory_parser (
    input logic          clk,
    input logic          rst_n,
    tdp_stream_if.sink   bytes,
    tdp_stream_if.source entries,
    tdp_stream_if.sink   cfg
);
    import tdp_pkg::*;

    phase_t      phase_reg, phase_next;
    logic        order_big_reg, order_big_next;
    logic [31:0] file_position_reg, file_position_next;
    logic [3:0]  byte_index_reg, byte_index_next;
    logic [31:0] word_buffer_reg, word_buffer_next;
    logic [31:0] directory_offset_reg, directory_offset_next;
    logic [15:0] entries_left_reg, entries_left_next;
    logic [15:0] current_tag_reg, current_tag_next;
    logic [15:0] current_type_reg, current_type_next;
    logic [31:0] current_count_reg, current_count_next;
    logic [15:0] entry_index_reg, entry_index_next;
    detail_tag_t detail_tag_reg;

    logic        out_valid_reg;
    entry_item_t out_payload_reg;
    entry_item_t result;
    logic        result_valid;
    logic        in_fire;

    function automatic logic [31:0] take_byte(input logic [31:0] wbuf, input logic [7:0] b,
                                              input logic [1:0] k, input logic big);
        logic [31:0] base;
        base = (k == 2'd0) ? 32'd0 : wbuf;
        if (big)
        begin
            return {base[23:0], b};
        end
        return base | ({24'd0, b} << {k, 3'b000});
    endfunction

    assign bytes.ready   = !out_valid_reg || entries.ready;
    assign in_fire       = bytes.valid && bytes.ready;
    assign cfg.ready     = 1'b1;
    assign entries.valid = out_valid_reg;
    assign entries.payload = out_payload_reg;

    always_comb
    begin
        logic [31:0] pos;
        logic [1:0]  sub;
        logic [31:0] wb;

        phase_next            = phase_reg;
        order_big_next        = order_big_reg;
        file_position_next    = file_position_reg;
        byte_index_next       = byte_index_reg;
        word_buffer_next      = word_buffer_reg;
        directory_offset_next = directory_offset_reg;
        entries_left_next     = entries_left_reg;
        current_tag_next      = current_tag_reg;
        current_type_next     = current_type_reg;
        current_count_next    = current_count_reg;
        entry_index_next      = entry_index_reg;
        result                = '0;
        result_valid          = 1'b0;
        sub                   = 2'd0;
        wb                    = 32'd0;

        if (bytes.payload.file_start)
        begin
            phase_next            = PH_ORDER;
            order_big_next        = 1'b0;
            file_position_next    = 32'd0;
            byte_index_next       = 4'd0;
            word_buffer_next      = 32'd0;
            directory_offset_next = 32'd0;
            entries_left_next     = 16'd0;
            current_tag_next      = 16'd0;
            current_type_next     = 16'd0;
            current_count_next    = 32'd0;
            entry_index_next      = 16'd0;
        end

        pos = file_position_next;
        if (file_position_next != 32'hFFFF_FFFF)
        begin
            file_position_next = file_position_next + 32'd1;
        end

        if (phase_next == PH_SKIP && pos == directory_offset_next)
        begin
            phase_next      = PH_COUNT;
            byte_index_next = 4'd0;
        end

        unique case (phase_next)
            PH_ORDER:
            begin
                if (byte_index_next == 4'd0)
                begin
                    word_buffer_next = {24'd0, bytes.payload.in_byte};
                    byte_index_next  = 4'd1;
                end
                else
                begin
                    byte_index_next = 4'd0;
                    if (bytes.payload.in_byte == ORDER_BIG_BYTE
                        && word_buffer_next == {24'd0, ORDER_BIG_BYTE})
                    begin
                        order_big_next = 1'b1;
                        phase_next     = PH_MAGIC;
                    end
                    else if (bytes.payload.in_byte == ORDER_LITTLE_BYTE
                             && word_buffer_next == {24'd0, ORDER_LITTLE_BYTE})
                    begin
                        order_big_next = 1'b0;
                        phase_next     = PH_MAGIC;
                    end
                    else
                    begin
                        order_big_next = 1'b0;
                        phase_next     = PH_ERROR;
                        result_valid   = 1'b1;
                        result.status  = ST_BAD_ORDER;
                    end
                end
            end
            PH_MAGIC:
            begin
                wb = take_byte(word_buffer_next, bytes.payload.in_byte,
                               byte_index_next[1:0], order_big_next);
                word_buffer_next = wb;
                if (byte_index_next == 4'd0)
                begin
                    byte_index_next = 4'd1;
                end
                else
                begin
                    byte_index_next = 4'd0;
                    if (wb[15:0] != TIFF_MAGIC)
                    begin
                        phase_next    = PH_ERROR;
                        result_valid  = 1'b1;
                        result.status = ST_BAD_MAGIC;
                    end
                    else
                    begin
                        phase_next = PH_OFFSET;
                    end
                end
            end
            PH_OFFSET:
            begin
                wb = take_byte(word_buffer_next, bytes.payload.in_byte,
                               byte_index_next[1:0], order_big_next);
                word_buffer_next = wb;
                if (byte_index_next < IDX_OFFSET_LAST)
                begin
                    byte_index_next = byte_index_next + 4'd1;
                end
                else
                begin
                    byte_index_next       = 4'd0;
                    directory_offset_next = wb;
                    if (wb < HEADER_BYTES)
                    begin
                        phase_next    = PH_ERROR;
                        result_valid  = 1'b1;
                        result.status = ST_BACKWARD;
                    end
                    else
                    begin
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_COUNT:
            begin
                wb = take_byte(word_buffer_next, bytes.payload.in_byte,
                               byte_index_next[1:0], order_big_next);
                word_buffer_next = wb;
                if (byte_index_next == 4'd0)
                begin
                    byte_index_next = 4'd1;
                end
                else
                begin
                    byte_index_next   = 4'd0;
                    entries_left_next = wb[15:0];
                    entry_index_next  = 16'd0;
                    phase_next        = (wb[15:0] != 16'd0) ? PH_ENTRY : PH_AFTER;
                end
            end
            PH_ENTRY:
            begin
                sub = (byte_index_next < 4'd4) ? {1'b0, byte_index_next[0]}
                                               : byte_index_next[1:0];
                wb = take_byte(word_buffer_next, bytes.payload.in_byte, sub,
                               order_big_next);
                word_buffer_next = wb;
                byte_index_next  = byte_index_next + 4'd1;
                if (byte_index_next == IDX_TAG_LAST + 4'd1)
                begin
                    current_tag_next = wb[15:0];
                end
                else if (byte_index_next == IDX_TYPE_LAST + 4'd1)
                begin
                    current_type_next = wb[15:0];
                    if (wb[15:0] < TYPE_FIRST || wb[15:0] > TYPE_LAST)
                    begin
                        phase_next          = PH_ERROR;
                        byte_index_next     = 4'd0;
                        result_valid        = 1'b1;
                        result.status       = ST_BAD_TYPE;
                        result.entry_tag    = current_tag_next;
                        result.entry_type   = wb[15:0];
                        result.entry_number = entry_index_next;
                        result.is_detail    = (current_tag_next == detail_tag_reg);
                    end
                end
                else if (byte_index_next == IDX_COUNT_LAST + 4'd1)
                begin
                    current_count_next = wb;
                end
                else if (byte_index_next > IDX_ENTRY_LAST)
                begin
                    byte_index_next     = 4'd0;
                    result_valid        = 1'b1;
                    result.status       = ST_ENTRY;
                    result.entry_tag    = current_tag_next;
                    result.entry_type   = current_type_next;
                    result.value_count  = current_count_next;
                    result.entry_value  = wb;
                    result.entry_number = entry_index_next;
                    result.is_detail    = (current_tag_next == detail_tag_reg);
                    entry_index_next    = entry_index_next + 16'd1;
                    entries_left_next   = entries_left_next - 16'd1;
                    if (entries_left_next == 16'd0)
                    begin
                        phase_next = PH_AFTER;
                    end
                end
            end
            PH_AFTER:
            begin
                phase_next          = PH_DONE;
                result_valid        = 1'b1;
                result.status       = ST_DIR_DONE;
                result.entry_number = entry_index_next;
            end
            PH_SKIP, PH_DONE, PH_ERROR:
            begin
            end
            default:
            begin
            end
        endcase

        result.big_endian = order_big_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_ORDER;
            order_big_reg        <= 1'b0;
            file_position_reg    <= 32'd0;
            byte_index_reg       <= 4'd0;
            word_buffer_reg      <= 32'd0;
            directory_offset_reg <= 32'd0;
            entries_left_reg     <= 16'd0;
            current_tag_reg      <= 16'd0;
            current_type_reg     <= 16'd0;
            current_count_reg    <= 32'd0;
            entry_index_reg      <= 16'd0;
            detail_tag_reg       <= DETAIL_TAG_RESET;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                detail_tag_reg <= cfg.payload;
            end
            if (in_fire)
            begin
                phase_reg            <= phase_next;
                order_big_reg        <= order_big_next;
                file_position_reg    <= file_position_next;
                byte_index_reg       <= byte_index_next;
                word_buffer_reg      <= word_buffer_next;
                directory_offset_reg <= directory_offset_next;
                entries_left_reg     <= entries_left_next;
                current_tag_reg      <= current_tag_next;
                current_type_reg     <= current_type_next;
                current_count_reg    <= current_count_next;
                entry_index_reg      <= entry_index_next;
                out_valid_reg        <= result_valid;
            end
            else if (entries.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && result_valid)
        begin
            out_payload_reg <= result;
        end
    end

    // A finished or failed file stays put until a new file starts.
    `TDP_ASSERT(a_terminal_sticky, clk, rst_n, in_fire && !bytes.payload.file_start && (phase_reg == PH_DONE || phase_reg == PH_ERROR) |=> phase_reg == $past(phase_reg))
    // Entry assembly only runs while entries remain in the directory.
    `TDP_ASSERT(a_entries_pending, clk, rst_n, phase_reg == PH_ENTRY |-> entries_left_reg != 16'd0 && byte_index_reg <= IDX_ENTRY_LAST)
    // No transaction is offered while reset is applied.
    `TDP_ASSERT_IN_RESET(a_reset_quiet, clk, rst_n, !out_valid_reg && phase_reg == PH_ORDER)

endmodule
